### src/ftba_pkg.sv
package ftba_pkg;

  localparam int FILE_SLOTS = 16;
  localparam int DISK_BLOCKS = 64;
  localparam int BLOCK_BYTES = 64;
  localparam int MAX_FILE_BLOCKS = 8;
  localparam int NAME_BYTES = 8;

  localparam int SLOT_W = $clog2(FILE_SLOTS);
  localparam int BLK_W = $clog2(DISK_BLOCKS);
  localparam int OFS_W = $clog2(BLOCK_BYTES);
  localparam int FBLK_W = $clog2(MAX_FILE_BLOCKS);
  localparam int MAP_W = SLOT_W + FBLK_W;
  localparam int DATA_W = BLK_W + OFS_W;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_WBEGIN = 3'd1;
  localparam logic [2:0] CMD_WBYTE = 3'd2;
  localparam logic [2:0] CMD_READ = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_EXISTS = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_LARGE = 3'd5;
  localparam logic [2:0] ST_DISKFULL = 3'd6;
  localparam logic [2:0] ST_PASTEND = 3'd7;

  // Result of one inode scan.
  typedef struct packed {
    logic                 found;
    logic [SLOT_W-1:0]    match_slot;
    logic                 has_free;
    logic [SLOT_W-1:0]    free_slot;
  } scan_res_t;

endpackage

### src/file_table_block_allocator.sv
// From accept to result: create, read, delete and write begin scan the inode
// table (one inode compared per cycle). Delete and write begin then free blocks
// one map entry at a time; write begin then searches the bitmap for each block
// it allocates. Write byte and unused codes skip the scan.
// Throughput: one item at a time; in_stall is high from accept to result.
// Reset: synchronous active-low rst_n clears inode table, bitmap and pending write.
module file_table_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [55:0] in_file_name,
  input  logic [15:0] in_total_length,
  input  logic [8:0]  in_byte_offset,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_inode_number,
  output logic [9:0]  out_byte_count,
  output logic [7:0]  out_read_data
);

  localparam int NS = ftba_pkg::FILE_SLOTS;
  localparam int SW = ftba_pkg::SLOT_W;
  localparam int BW = ftba_pkg::BLK_W;
  localparam int FW = ftba_pkg::FBLK_W;

  typedef enum logic [3:0] {
    M_IDLE, M_SCAN, M_WAIT, M_DECIDE, M_FREE_RD, M_FREE, M_ALLOC, M_WBYTE,
    M_RD_MAP, M_RD_DATA, M_RD_OUT, M_OUT
  } mstate_t;

  mstate_t state_r;

  // Inode table.
  logic [NS-1:0] ivalid_r;
  logic [55:0]   ikey_r [NS];
  logic [9:0]    ilen_r [NS];
  logic [FW:0]   itot_r [NS];
  logic [ftba_pkg::DISK_BLOCKS-1:0] used_r;

  // Memories.
  logic [BW-1:0] map_mem [ftba_pkg::FILE_SLOTS*ftba_pkg::MAX_FILE_BLOCKS];
  logic [7:0]    data_mem [ftba_pkg::DISK_BLOCKS*ftba_pkg::BLOCK_BYTES];
  logic [BW-1:0] map_q_r;
  logic [7:0]    data_q_r;

  // Captured item.
  logic [2:0]  cmd_r;
  logic [55:0] key_r;
  logic        name_ok_r;
  logic [15:0] tot_r;
  logic [8:0]  ofs_r;
  logic [7:0]  db_r;

  logic [SW-1:0] pend_ino_r;
  logic [9:0]    pend_pos_r;
  logic          pend_act_r;

  logic [SW-1:0] slot_r;
  logic [FW:0]   cnt_r;
  logic [FW+7:0] need_r;
  logic [BW:0]   bidx_r;

  logic [2:0]  st_r;
  logic [3:0]  ino_r;
  logic [9:0]  bc_r;
  logic [7:0]  rd_r;

  // Name key truncates at the first zero byte.
  logic [55:0] name_key;
  logic [3:0]  name_len;
  always_comb begin
    logic stop;
    name_key = '0;
    name_len = '0;
    stop = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (!stop && in_file_name[8*i +: 8] != 8'd0) begin
        name_key[8*i +: 8] = in_file_name[8*i +: 8];
        name_len = name_len + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
  end

  logic                scan_start;
  logic [SW-1:0]       scan_idx;
  logic                scan_done;
  ftba_pkg::scan_res_t scan_res;

  ftba_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .key       (key_r),
    .valid_vec (ivalid_r),
    .slot_key  (ikey_r[scan_idx]),
    .slot_idx  (scan_idx),
    .done      (scan_done),
    .res       (scan_res)
  );

  assign scan_start = (state_r == M_SCAN);
  assign in_stall = (state_r != M_IDLE);
  assign out_valid = (state_r == M_OUT);
  assign out_status = st_r;
  assign out_inode_number = ino_r;
  assign out_byte_count = bc_r;
  assign out_read_data = rd_r;

  logic [SW-1:0] ws;
  logic [8:0]    wpos;
  assign ws = pend_ino_r;
  assign wpos = pend_pos_r[8:0];

  // Memory ports.
  logic [ftba_pkg::MAP_W-1:0]  map_raddr;
  logic [ftba_pkg::DATA_W-1:0] data_addr;
  always_comb begin
    map_raddr = {slot_r, cnt_r[FW-1:0]};
    data_addr = {map_q_r, ofs_r[ftba_pkg::OFS_W-1:0]};
    if (state_r == M_WBYTE) begin
      map_raddr = {ws, wpos[ftba_pkg::OFS_W +: FW]};
    end else if (state_r == M_RD_MAP) begin
      map_raddr = {slot_r, ofs_r[ftba_pkg::OFS_W +: FW]};
    end
  end

  always_ff @(posedge clk) begin
    map_q_r <= map_mem[map_raddr];
    if (state_r == M_ALLOC && !used_r[bidx_r[BW-1:0]] && cnt_r != need_r[FW:0]) begin
      map_mem[{slot_r, cnt_r[FW-1:0]}] <= bidx_r[BW-1:0];
    end
    data_q_r <= data_mem[data_addr];
    if (state_r == M_RD_OUT && cmd_r == ftba_pkg::CMD_WBYTE) begin
      data_mem[{map_q_r, wpos[ftba_pkg::OFS_W-1:0] - 6'(0)}] <= db_r;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      ivalid_r <= '0;
      used_r <= '0;
      pend_act_r <= 1'b0;
      pend_ino_r <= '0;
      pend_pos_r <= '0;
      for (int i = 0; i < NS; i++) begin
        ikey_r[i] <= '0;
        ilen_r[i] <= '0;
        itot_r[i] <= '0;
      end
    end else begin
      case (state_r)
        M_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command;
            key_r <= name_key;
            name_ok_r <= (name_len != 4'd0) && (name_len < 4'(ftba_pkg::NAME_BYTES));
            tot_r <= in_total_length;
            ofs_r <= in_byte_offset;
            db_r <= in_data_byte;
            st_r <= ftba_pkg::ST_OK;
            ino_r <= '0;
            bc_r <= '0;
            rd_r <= '0;
            if (in_command == ftba_pkg::CMD_WBYTE) begin
              if (pend_act_r) begin
                state_r <= M_WBYTE;
              end else begin
                st_r <= ftba_pkg::ST_PASTEND;
                state_r <= M_OUT;
              end
            end else if (in_command > ftba_pkg::CMD_DELETE) begin
              state_r <= M_OUT;
            end else begin
              state_r <= M_SCAN;
            end
          end
        end
        M_SCAN: state_r <= M_WAIT;
        M_WAIT: if (scan_done) state_r <= M_DECIDE;
        M_DECIDE: begin
          slot_r <= scan_res.match_slot;
          cnt_r <= '0;
          state_r <= M_OUT;
          if (cmd_r == ftba_pkg::CMD_CREATE) begin
            if (!name_ok_r) begin
              st_r <= ftba_pkg::ST_EMPTY;
            end else if (scan_res.found) begin
              st_r <= ftba_pkg::ST_EXISTS;
              ino_r <= 4'(scan_res.match_slot);
            end else if (!scan_res.has_free) begin
              st_r <= ftba_pkg::ST_FULL;
            end else begin
              ivalid_r[scan_res.free_slot] <= 1'b1;
              ikey_r[scan_res.free_slot] <= key_r;
              ilen_r[scan_res.free_slot] <= '0;
              itot_r[scan_res.free_slot] <= '0;
              ino_r <= 4'(scan_res.free_slot);
            end
          end else begin
            if (cmd_r == ftba_pkg::CMD_WBEGIN) pend_act_r <= 1'b0;
            if (!(name_ok_r && scan_res.found)) begin
              st_r <= ftba_pkg::ST_NOTFOUND;
            end else begin
              ino_r <= 4'(scan_res.match_slot);
              if (cmd_r == ftba_pkg::CMD_READ) begin
                bc_r <= ilen_r[scan_res.match_slot];
                if ({7'd0, ofs_r} >= {6'd0, ilen_r[scan_res.match_slot]}) begin
                  st_r <= ftba_pkg::ST_PASTEND;
                end else begin
                  state_r <= M_RD_MAP;
                end
              end else begin
                need_r <= (FW+8)'((17'(tot_r) + 17'(ftba_pkg::BLOCK_BYTES - 1))
                          >> ftba_pkg::OFS_W);
                state_r <= M_FREE_RD;
                if (cmd_r == ftba_pkg::CMD_DELETE) begin
                  ivalid_r[scan_res.match_slot] <= 1'b0;
                  ikey_r[scan_res.match_slot] <= '0;
                  if (pend_act_r && pend_ino_r == scan_res.match_slot) begin
                    pend_act_r <= 1'b0;
                  end
                end
              end
            end
          end
        end
        // Release blocks one map entry at a time.
        M_FREE_RD: begin
          if (cnt_r == itot_r[slot_r]) begin
            itot_r[slot_r] <= '0;
            ilen_r[slot_r] <= '0;
            cnt_r <= '0;
            bidx_r <= '0;
            if (cmd_r == ftba_pkg::CMD_DELETE) begin
              state_r <= M_OUT;
            end else if (need_r > (FW+8)'(ftba_pkg::MAX_FILE_BLOCKS)) begin
              st_r <= ftba_pkg::ST_LARGE;
              state_r <= M_OUT;
            end else begin
              state_r <= M_ALLOC;
            end
          end else begin
            state_r <= M_FREE;
          end
        end
        M_FREE: begin
          used_r[map_q_r] <= 1'b0;
          cnt_r <= cnt_r + 1'b1;
          state_r <= M_FREE_RD;
        end
        // Lowest-free-first bitmap search, one block per cycle.
        M_ALLOC: begin
          if (cnt_r == need_r[FW:0]) begin
            ilen_r[slot_r] <= tot_r[9:0];
            bc_r <= tot_r[9:0];
            pend_ino_r <= slot_r;
            pend_pos_r <= '0;
            pend_act_r <= (tot_r != 16'd0);
            state_r <= M_OUT;
          end else if (bidx_r == (BW+1)'(ftba_pkg::DISK_BLOCKS)) begin
            st_r <= ftba_pkg::ST_DISKFULL;
            state_r <= M_OUT;
          end else if (!used_r[bidx_r[BW-1:0]]) begin
            used_r[bidx_r[BW-1:0]] <= 1'b1;
            itot_r[slot_r] <= cnt_r + 1'b1;
            cnt_r <= cnt_r + 1'b1;
            bidx_r <= '0;
          end else begin
            bidx_r <= bidx_r + 1'b1;
          end
        end
        M_WBYTE: state_r <= M_RD_OUT;
        M_RD_MAP: state_r <= M_RD_DATA;
        M_RD_DATA: state_r <= M_RD_OUT;
        M_RD_OUT: begin
          if (cmd_r == ftba_pkg::CMD_WBYTE) begin
            pend_pos_r <= pend_pos_r + 10'd1;
            if (pend_pos_r + 10'd1 >= ilen_r[ws]) pend_act_r <= 1'b0;
            ino_r <= 4'(ws);
            bc_r <= pend_pos_r + 10'd1;
          end else begin
            rd_r <= data_q_r;
          end
          state_r <= M_OUT;
        end
        M_OUT: if (!out_stall) state_r <= M_IDLE;
        default: state_r <= M_IDLE;
      endcase
    end
  end

  // A result is only offered while the input side is stalled.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
    else $error("result shown while accepting");
  // An accepted item always leaves the idle state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accept did not start work");
  // A pending write always points at a live inode.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_IDLE && pend_act_r) |-> ivalid_r[pend_ino_r])
    else $error("pending write on dead inode");

endmodule

### src/ftba_scan.sv
// Walks the inode table one slot per cycle, comparing keys and noting the
// lowest free slot.
module ftba_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [55:0]                   key,
  input  logic [ftba_pkg::FILE_SLOTS-1:0] valid_vec,
  input  logic [55:0]                   slot_key,
  output logic [ftba_pkg::SLOT_W-1:0]   slot_idx,
  output logic                          done,
  output ftba_pkg::scan_res_t           res
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} sstate_t;

  sstate_t                   state_r;
  logic [ftba_pkg::SLOT_W:0] idx_r;
  ftba_pkg::scan_res_t       res_r;

  assign slot_idx = idx_r[ftba_pkg::SLOT_W-1:0];
  assign done = (state_r == S_DONE);
  assign res = res_r;

  // One compare per cycle; first hit wins.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      res_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            idx_r <= '0;
            res_r <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (valid_vec[slot_idx] && slot_key == key && !res_r.found) begin
            res_r.found <= 1'b1;
            res_r.match_slot <= slot_idx;
          end
          if (!valid_vec[slot_idx] && !res_r.has_free) begin
            res_r.has_free <= 1'b1;
            res_r.free_slot <= slot_idx;
          end
          if (idx_r == (ftba_pkg::SLOT_W+1)'(ftba_pkg::FILE_SLOTS - 1)) begin
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/tb.sv
module tb;

  localparam int ITEM_GOAL = 1150;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int POOL_SIZE = 20;
  localparam int FILE_SLOTS = ftba_pkg::FILE_SLOTS;
  localparam int DISK_BLOCKS = ftba_pkg::DISK_BLOCKS;
  localparam int BLOCK_BYTES = ftba_pkg::BLOCK_BYTES;
  localparam int MAX_FILE_BLOCKS = ftba_pkg::MAX_FILE_BLOCKS;
  localparam int NAME_BYTES = ftba_pkg::NAME_BYTES;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] inode;
    logic [9:0] count;
    logic [7:0] data;
  } fs_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [55:0] in_file_name;
  logic [15:0] in_total_length;
  logic [8:0]  in_byte_offset;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [3:0]  out_inode_number;
  logic [9:0]  out_byte_count;
  logic [7:0]  out_read_data;

  file_table_block_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_file_name(in_file_name), .in_total_length(in_total_length),
    .in_byte_offset(in_byte_offset), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_inode_number(out_inode_number), .out_byte_count(out_byte_count),
    .out_read_data(out_read_data)
  );

  // Shadow copy of the file store.
  bit          slot_used [FILE_SLOTS];
  logic [55:0] slot_key [FILE_SLOTS];
  int          slot_len [FILE_SLOTS];
  int          slot_nblk [FILE_SLOTS];
  int          slot_map [FILE_SLOTS][MAX_FILE_BLOCKS];
  bit          blk_busy [DISK_BLOCKS];
  logic [7:0]  disk [DISK_BLOCKS*BLOCK_BYTES];
  bit          disk_written [DISK_BLOCKS*BLOCK_BYTES];
  int          wr_slot;
  int          wr_pos;
  bit          wr_on;

  fs_result_t  pending_results [$];
  logic [55:0] name_pool [POOL_SIZE];
  int          items_sent;
  int          results_seen;
  int          errors;
  int          cycles = 0;
  bit          no_idle;
  bit [7:0]    status_seen;

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("file_table_block_allocator verification failed");
      $finish;
    end
  end

  // Split a raw name at its first zero byte.
  function automatic void split_name(input logic [55:0] raw, output logic [55:0] key,
                                     output int n);
    bit stop;
    key = '0;
    n = 0;
    stop = 0;
    for (int i = 0; i < 7; i++) begin
      if (!stop) begin
        if (raw[8*i +: 8] == 8'd0) stop = 1;
        else begin
          key[8*i +: 8] = raw[8*i +: 8];
          n = i + 1;
        end
      end
    end
  endfunction

  function automatic int find_file(input logic [55:0] key, input int n);
    int hit;
    hit = -1;
    if (n == 0 || n >= NAME_BYTES) return -1;
    for (int i = FILE_SLOTS - 1; i >= 0; i--)
      if (slot_used[i] && slot_key[i] == key) hit = i;
    return hit;
  endfunction

  function automatic int disk_addr(input int s, input int pos);
    int b;
    if (pos / BLOCK_BYTES >= MAX_FILE_BLOCKS) return 0;
    b = slot_map[s][pos / BLOCK_BYTES];
    return b * BLOCK_BYTES + pos % BLOCK_BYTES;
  endfunction

  function automatic void free_file_blocks(input int s);
    for (int i = 0; i < slot_nblk[s] && i < MAX_FILE_BLOCKS; i++)
      blk_busy[slot_map[s][i]] = 0;
    slot_nblk[s] = 0;
    slot_len[s] = 0;
  endfunction

  // Apply one command to the shadow store and return its result.
  function automatic fs_result_t apply_file_op(input logic [2:0] cmd,
      input logic [55:0] raw, input int total, input int ofs, input logic [7:0] dat);
    fs_result_t r;
    logic [55:0] key;
    int n, s, need, b, a;
    r = '0;
    split_name(raw, key, n);
    case (cmd)
      ftba_pkg::CMD_CREATE: begin
        s = find_file(key, n);
        if (n == 0 || n >= NAME_BYTES) r.status = ftba_pkg::ST_EMPTY;
        else if (s >= 0) begin
          r.status = ftba_pkg::ST_EXISTS;
          r.inode = s[3:0];
        end else begin
          r.status = ftba_pkg::ST_FULL;
          for (int i = 0; i < FILE_SLOTS; i++) begin
            if (r.status == ftba_pkg::ST_FULL && !slot_used[i]) begin
              slot_used[i] = 1;
              slot_key[i] = key;
              slot_len[i] = 0;
              slot_nblk[i] = 0;
              r.status = ftba_pkg::ST_OK;
              r.inode = i[3:0];
            end
          end
        end
      end
      ftba_pkg::CMD_WBEGIN: begin
        s = find_file(key, n);
        wr_on = 0;
        if (s < 0) r.status = ftba_pkg::ST_NOTFOUND;
        else begin
          r.inode = s[3:0];
          free_file_blocks(s);
          need = (total + BLOCK_BYTES - 1) / BLOCK_BYTES;
          if (need > MAX_FILE_BLOCKS) r.status = ftba_pkg::ST_LARGE;
          else begin
            for (int i = 0; i < need; i++) begin
              if (r.status == ftba_pkg::ST_OK) begin
                b = -1;
                for (int j = DISK_BLOCKS - 1; j >= 0; j--)
                  if (!blk_busy[j]) b = j;
                if (b < 0) r.status = ftba_pkg::ST_DISKFULL;
                else begin
                  blk_busy[b] = 1;
                  slot_map[s][i] = b;
                  slot_nblk[s] = i + 1;
                end
              end
            end
            if (r.status == ftba_pkg::ST_OK) begin
              slot_len[s] = total;
              r.count = total[9:0];
              wr_slot = s;
              wr_pos = 0;
              wr_on = (total != 0);
            end
          end
        end
      end
      ftba_pkg::CMD_WBYTE: begin
        if (!wr_on) r.status = ftba_pkg::ST_PASTEND;
        else begin
          a = disk_addr(wr_slot, wr_pos);
          disk[a] = dat;
          disk_written[a] = 1;
          wr_pos++;
          if (wr_pos >= slot_len[wr_slot]) wr_on = 0;
          r.inode = wr_slot[3:0];
          r.count = wr_pos[9:0];
        end
      end
      ftba_pkg::CMD_READ: begin
        s = find_file(key, n);
        if (s < 0) r.status = ftba_pkg::ST_NOTFOUND;
        else begin
          r.inode = s[3:0];
          r.count = slot_len[s][9:0];
          if (ofs >= slot_len[s]) r.status = ftba_pkg::ST_PASTEND;
          else r.data = disk[disk_addr(s, ofs)];
        end
      end
      ftba_pkg::CMD_DELETE: begin
        s = find_file(key, n);
        if (s < 0) r.status = ftba_pkg::ST_NOTFOUND;
        else begin
          r.inode = s[3:0];
          free_file_blocks(s);
          slot_used[s] = 0;
          slot_key[s] = '0;
          if (wr_on && wr_slot == s) wr_on = 0;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Send one item after a random gap (none while no_idle is set), then record its expected result.
  task automatic send_item(input logic [2:0] cmd, input logic [55:0] raw,
                           input logic [15:0] total, input logic [8:0] ofs,
                           input logic [7:0] dat);
    logic [55:0] key;
    int n, s, gap;
    gap = 0;
    if (!no_idle)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
    repeat (1 + gap) @(posedge clk);
    // A byte inside the file that was never written must not be read.
    if (cmd == ftba_pkg::CMD_READ) begin
      split_name(raw, key, n);
      s = find_file(key, n);
      if (s >= 0 && ofs < slot_len[s])
        if (!disk_written[disk_addr(s, ofs)]) raw = '0;
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_file_name <= raw;
    in_total_length <= total;
    in_byte_offset <= ofs;
    in_data_byte <= dat;
    do @(posedge clk); while (!(in_valid && !in_stall));
    in_valid <= 1'b0;
    pending_results.push_back(apply_file_op(cmd, raw, total, ofs, dat));
    items_sent++;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    fs_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_seen[out_status] = 1'b1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_inode_number !== want.inode) begin
          $display("%0t: inode expected %0d actual %0d", $time, want.inode,
                   out_inode_number);
          errors++;
        end
        if (out_byte_count !== want.count) begin
          $display("%0t: byte count expected %0d actual %0d", $time, want.count,
                   out_byte_count);
          errors++;
        end
        if (out_read_data !== want.data) begin
          $display("%0t: read data expected %0h actual %0h", $time, want.data,
                   out_read_data);
          errors++;
        end
      end
    end
  end

  // Receiver stalls: mostly short, a few long.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      if (no_idle) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 50);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Directed checks of the edge cases.
  task automatic test_directed();
    logic [55:0] name_a;
    name_a = 56'h41;
    send_item(ftba_pkg::CMD_CREATE, 56'h0, 16'd0, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_CREATE, 56'hFF_FFFF_FFFF_FFFF, 16'd0, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_CREATE, 56'h37_3635_3433_3231, 16'd0, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_CREATE, name_a, 16'd0, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_CREATE, name_a | 56'hAB_CD00_0000_0000, 16'd0, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_WBEGIN, name_a, 16'd3, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_WBYTE, 56'h0, 16'd0, 9'd0, 8'h00);
    send_item(ftba_pkg::CMD_WBYTE, 56'h0, 16'd0, 9'd0, 8'hFF);
    send_item(ftba_pkg::CMD_WBYTE, 56'h0, 16'd0, 9'd0, 8'h5A);
    send_item(ftba_pkg::CMD_WBYTE, 56'h0, 16'd0, 9'd0, 8'h11);
    send_item(ftba_pkg::CMD_READ, name_a, 16'd0, 9'd1, 8'd0);
    send_item(ftba_pkg::CMD_READ, name_a, 16'd0, 9'd3, 8'd0);
    send_item(ftba_pkg::CMD_READ, name_a, 16'd0, 9'd511, 8'd0);
    send_item(ftba_pkg::CMD_READ, 56'h42, 16'd0, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_WBEGIN, 56'h37_3635_3433_3231, 16'd512, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_WBEGIN, name_a, 16'hFFFF, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_WBEGIN, name_a, 16'd512, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_WBEGIN, name_a, 16'd0, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_WBEGIN, name_a, 16'd513, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_DELETE, name_a, 16'd0, 9'd0, 8'd0);
    send_item(ftba_pkg::CMD_DELETE, name_a, 16'd0, 9'd0, 8'd0);
    for (int c = int'(ftba_pkg::CMD_DELETE) + 1; c < 8; c++)
      send_item(c[2:0], {56{1'b1}}, 16'hFFFF, 9'h1FF, 8'hFF);
  endtask

  // One create, write and read-back sequence on a pool file.
  task automatic file_session(input logic [55:0] nm);
    int len, nbytes, nreads;
    case ($urandom_range(0, 19))
      0: len = 0;
      1: len = $urandom_range(0, 65535);
      2, 3: len = $urandom_range(300, 600);
      default: len = $urandom_range(1, 90);
    endcase
    nbytes = (len <= 96) ? len : $urandom_range(0, 40);
    if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, nbytes);
    send_item(ftba_pkg::CMD_CREATE, nm, 16'($urandom), 9'($urandom), 8'($urandom));
    send_item(ftba_pkg::CMD_WBEGIN, nm, len[15:0], 9'($urandom), 8'($urandom));
    for (int i = 0; i < nbytes; i++)
      send_item(ftba_pkg::CMD_WBYTE, 56'($urandom), 16'($urandom), 9'($urandom),
                8'($urandom));
    nreads = $urandom_range(1, 4);
    for (int i = 0; i < nreads; i++)
      send_item(ftba_pkg::CMD_READ, nm, 16'($urandom),
                9'($urandom_range(0, (nbytes > 0) ? nbytes : 8)), 8'($urandom));
  endtask

  // Random mix of sessions, deletes, stray reads and noise.
  task automatic test_random(input int goal);
    logic [55:0] nm;
    int pick;
    while (items_sent < goal) begin
      nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 55) file_session(nm);
      else if (pick < 70)
        send_item(ftba_pkg::CMD_DELETE, nm, 16'($urandom), 9'($urandom), 8'($urandom));
      else if (pick < 80)
        send_item(ftba_pkg::CMD_READ, nm, 16'($urandom), 9'($urandom), 8'($urandom));
      else if (pick < 90)
        send_item(ftba_pkg::CMD_CREATE, nm, 16'($urandom), 9'($urandom), 8'($urandom));
      else
        send_item(3'($urandom_range(0, 7)), {24'($urandom), 32'($urandom)},
                  16'($urandom), 9'($urandom), 8'($urandom));
    end
  endtask

  // Sender holds off until the block has answered everything.
  task automatic test_pause();
    drain_results();
    repeat (30) @(posedge clk);
    send_item(ftba_pkg::CMD_READ, name_pool[0], 16'd0, 9'd0, 8'd0);
  endtask

  // Names of one to seven chars, some with junk after the terminator.
  task automatic build_name_pool();
    int n;
    for (int i = 0; i < POOL_SIZE; i++) begin
      n = 1 + (i % 7);
      name_pool[i] = '0;
      for (int j = 0; j < n; j++)
        name_pool[i][8*j +: 8] = (j == 0) ? 8'(8'h41 + i) : 8'($urandom_range(1, 255));
      if (n < 6 && (i % 2)) name_pool[i][8*(n+1) +: 8] = 8'($urandom_range(1, 255));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = '0;
    in_file_name = '0;
    in_total_length = '0;
    in_byte_offset = '0;
    in_data_byte = '0;
    items_sent = 0;
    results_seen = 0;
    errors = 0;
    status_seen = '0;
    no_idle = 1'b0;
    wr_on = 0;
    wr_slot = 0;
    wr_pos = 0;
    for (int i = 0; i < FILE_SLOTS; i++) begin
      slot_used[i] = 0;
      slot_key[i] = '0;
      slot_len[i] = 0;
      slot_nblk[i] = 0;
      for (int j = 0; j < MAX_FILE_BLOCKS; j++) slot_map[i][j] = 0;
    end
    for (int i = 0; i < DISK_BLOCKS; i++) blk_busy[i] = 0;
    for (int i = 0; i < DISK_BLOCKS * BLOCK_BYTES; i++) begin
      disk[i] = '0;
      disk_written[i] = 0;
    end
    build_name_pool();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(ITEM_GOAL / 3);
    test_pause();
    // A stretch with no idling on either side.
    no_idle = 1'b1;
    test_random(ITEM_GOAL / 2);
    no_idle = 1'b0;
    test_random(ITEM_GOAL);

    drain_results();
    repeat (60) @(posedge clk);
    $display("Sent %0d items and checked %0d results.", items_sent, results_seen);
    $display("Status codes observed (bit per code): %b", status_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("file_table_block_allocator verification clean");
    else
      $display("file_table_block_allocator verification failed");
    $finish;
  end

endmodule

### files.f
src/ftba_pkg.sv
src/ftba_scan.sv
src/file_table_block_allocator.sv
tb/tb.sv
